### rtl/c8i_pkg.sv
// Shared types, constants and helper functions for the CHIP-8 interpreter core.
// Used by c8i_mem and chip8_interpreter_core_top. No dependencies.
`default_nettype none
package c8i_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int ADDR_W        = 12;
	localparam int STACK_DEPTH_D = 16;
	localparam int SCREEN_W_D    = 64;
	localparam int SCREEN_H_D    = 32;

	localparam logic [ADDR_W-1:0] FONT_BASE    = 12'h050;
	localparam logic [ADDR_W-1:0] PROGRAM_BASE = 12'h200;
	localparam int                FONT_BYTES   = 80;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_EXEC = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	function automatic logic [7:0] glyph(input logic [6:0] idx);
		logic [7:0] g;
		case (idx)
			7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
			7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45,
			7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75,
			7'd77: g = 8'hF0;
			7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
			7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: g = 8'h90;
			7'd5, 7'd7, 7'd8, 7'd37: g = 8'h20;
			7'd6: g = 8'h60;
			7'd9: g = 8'h70;
			7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: g = 8'h10;
			7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
			7'd78, 7'd79: g = 8'h80;
			7'd38, 7'd39: g = 8'h40;
			7'd55, 7'd57, 7'd59, 7'd65, 7'd69: g = 8'hE0;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// {hundreds, tens, ones}
	function automatic logic [11:0] bcd(input logic [7:0] v);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [15:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - 8'(h) * 8'd100;
		p = 16'(r) * 16'd205;
		t = p[14:11];
		o = r - 8'(t) * 8'd10;
		return {2'b00, h, t, o[3:0]};
	endfunction

	// v mod d, with recip = floor(65536 / d)
	function automatic logic [7:0] mod_const(input logic [7:0] v, input logic [7:0] d,
			input logic [16:0] recip);
		logic [24:0] p;
		logic [7:0]  q;
		logic [7:0]  r;
		p = 25'(v) * 25'(recip);
		q = p[23:16];
		r = v - 8'(16'(q) * 16'(d));
		if (r >= d) begin
			r = r - d;
		end
		return r;
	endfunction

	function automatic logic [4:0] low_key(input logic [15:0] keys);
		logic [4:0] k;
		k = 5'h10;
		for (int i = 15; i >= 0; i--) begin
			if (keys[i]) begin
				k = 5'(i);
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/c8i_mem.sv
// Main memory of the CHIP-8 core: 4096 x 8 synchronous RAM, one port.
// Runs a font and zero fill sweep after reset. Depends on c8i_pkg.
`default_nettype none
module c8i_mem (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire c8i_pkg::mem_req_t req,
	output logic [7:0]            rdata,
	output logic                  ready
);
	localparam int CW = c8i_pkg::ADDR_W + 1;

	logic [7:0]                     ram_q [c8i_pkg::MEM_BYTES];
	logic [CW-1:0]                  clr_q;
	logic [c8i_pkg::ADDR_W-1:0]     fill_addr;
	logic [c8i_pkg::ADDR_W-1:0]     font_off;
	logic [7:0]                     fill_data;

	assign ready     = clr_q[CW-1];
	assign fill_addr = clr_q[CW-2:0];
	assign font_off  = fill_addr - c8i_pkg::FONT_BASE;
	assign fill_data = (fill_addr >= c8i_pkg::FONT_BASE &&
			fill_addr < c8i_pkg::FONT_BASE + 12'(c8i_pkg::FONT_BYTES)) ?
			c8i_pkg::glyph(font_off[6:0]) : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!ready) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ready) begin
			ram_q[fill_addr] <= fill_data;
		end else if (req.we) begin
			ram_q[req.addr] <= req.wdata;
		end
		rdata <= ram_q[req.addr];
	end
endmodule
`default_nettype wire

### rtl/chip8_interpreter_core_top.sv
// Top level of the CHIP-8 interpreter core: sequencer, register file, stack, display.
// Depends on c8i_pkg and c8i_mem.
//
// Input channel (in_valid / in_stall) carries one transaction per command:
// load writes a program byte, execute runs one instruction, read returns a row.
// Output channel (out_valid / out_stall) returns one status transaction per input.
// After reset the main memory is filled with the font and zeros by a sweep of
// every address; in_stall stays high during that sweep.
// A load passes S_LOAD, a read S_RR and S_RR2, and a plain instruction S_FHI,
// S_FLO, S_RX, S_RY, S_EXEC and S_FIN, each then S_OUT; out_valid rises in the
// same cycle as the next input can be taken. 8XY4..8XYE add S_FLAG for the flag
// write, FX33 adds an S_BCD write per digit, FX55 and FX65 add a read and a write
// per register, and DXYN adds a read and a write per sprite row, a check and S_FLAG.
// The block handles one transaction at a time; every access goes through the
// single port of the main memory, which paces each command.
// The result sits in an output register; the next input transaction is taken
// while it waits. When out_stall holds, the following result waits in the
// sequencer until the output register frees.
`default_nettype none
module chip8_interpreter_core_top #(
	parameter int STACK_DEPTH   = c8i_pkg::STACK_DEPTH_D,
	parameter int SCREEN_WIDTH  = c8i_pkg::SCREEN_W_D,
	parameter int SCREEN_HEIGHT = c8i_pkg::SCREEN_H_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  data,
	input  wire logic [15:0] key_mask,
	input  wire logic [7:0]  random_byte,
	input  wire logic [4:0]  row_select,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      program_counter,
	output logic [15:0]      last_opcode,
	output logic [7:0]       delay_count,
	output logic             sound_on,
	output logic [63:0]      row_pixels,
	output logic             waiting_key
);
	localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FA  = $clog2(SCREEN_HEIGHT);
	localparam logic [16:0] RECIP_W = 17'(65536 / SCREEN_WIDTH);
	localparam logic [16:0] RECIP_H = 17'(65536 / SCREEN_HEIGHT);
	localparam logic [63:0] COL_MASK = ~({64{1'b1}} >> SCREEN_WIDTH);
	localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_RR, S_RR2, S_FHI, S_FLO, S_RX, S_RY, S_EXEC,
		S_FLAG, S_DRD, S_DWR, S_BCD, S_STR, S_STW, S_LDR, S_LDW, S_FIN, S_OUT
	} state_t;

	state_t            state_q;
	logic [1:0]        cmd_q;
	logic [11:0]       addr_q;
	logic [7:0]        data_q;
	logic [15:0]       key_q;
	logic [7:0]        rnd_q;
	logic [4:0]        rsel_q;

	logic [11:0]       pc_q;
	logic [11:0]       i_q;
	logic [SPW-1:0]    sp_q;
	logic [7:0]        delay_q;
	logic [7:0]        sound_q;
	logic [15:0]       seen_q;
	logic [7:0]        op_hi_q;
	logic [15:0]       op_q;
	logic [7:0]        vx_q;
	logic [3:0]        cnt_q;
	logic [5:0]        x0_q;
	logic [5:0]        y0_q;
	logic [6:0]        drow_q;
	logic              hit_q;
	logic              flag_q;
	logic [11:0]       bcd_q;
	logic              waiting_q;
	logic [63:0]       row_q;

	logic              out_valid_q;
	logic [11:0]       pc_out_q;
	logic [15:0]       op_out_q;
	logic [7:0]        delay_out_q;
	logic              sound_out_q;
	logic [63:0]       row_out_q;
	logic              wait_out_q;

	logic [7:0]        regs_q [16];
	logic [15:0]       rv_q;
	logic [7:0]        rf_rd_q;
	logic [3:0]        rf_ra;
	logic              rf_we_q;
	logic [3:0]        rf_wa_q;
	logic [7:0]        rf_wd_q;

	logic [11:0]       stack_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] sv_q;
	logic [SPW-1:0]    sp_dec;
	logic [SPW-1:0]    sp_inc;

	logic [63:0]       frame_q [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] fv_q;
	logic [63:0]       fr_rd_q;
	logic [FA-1:0]     fr_ra;
	logic [63:0]       draw_mask;

	c8i_pkg::mem_req_t mem_req;
	logic [7:0]        mem_rdata;
	logic              mem_ready;

	logic [3:0]        ox;
	logic [3:0]        oy;
	logic [7:0]        kk;
	logic [11:0]       nnn;
	logic [11:0]       pc_skip;
	logic [6:0]        drow;
	logic [8:0]        add9;
	logic [4:0]        lk;
	logic              accept;
	logic              out_free;

	c8i_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

	assign ox       = op_q[11:8];
	assign oy       = op_q[7:4];
	assign kk       = op_q[7:0];
	assign nnn      = op_q[11:0];
	assign pc_skip  = pc_q + 12'd2;
	assign drow     = {1'b0, y0_q} + 7'(cnt_q);
	assign add9     = {1'b0, vx_q} + {1'b0, rf_rd_q};
	assign lk       = c8i_pkg::low_key(key_q);
	assign sp_dec   = (sp_q == '0) ? SP_LAST : sp_q - 1'b1;
	assign sp_inc   = (sp_q == SP_LAST) ? '0 : sp_q + 1'b1;
	assign draw_mask = ({mem_rdata, 56'b0} >> x0_q) & COL_MASK;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && mem_ready);

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_LOAD: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = addr_q;
				mem_req.wdata = data_q;
			end
			S_FHI: mem_req.addr = pc_q;
			S_FLO: mem_req.addr = pc_q + 12'd1;
			S_DRD: mem_req.addr = i_q + 12'(cnt_q);
			S_LDR: mem_req.addr = i_q + 12'(cnt_q);
			S_BCD: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = i_q + 12'(cnt_q);
				mem_req.wdata = (cnt_q == 4'd0) ? {4'h0, bcd_q[11:8]} :
						((cnt_q == 4'd1) ? {4'h0, bcd_q[7:4]} : {4'h0, bcd_q[3:0]});
			end
			S_STW: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = i_q + 12'(cnt_q);
				mem_req.wdata = rf_rd_q;
			end
			default: mem_req = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_RX:    rf_ra = op_hi_q[3:0];
			S_RY:    rf_ra = (op_q[15:12] == 4'hB) ? 4'h0 : oy;
			S_STR:   rf_ra = cnt_q;
			default: rf_ra = ox;
		endcase
	end

	always_comb begin
		case (state_q)
			S_DRD:   fr_ra = FA'(drow);
			default: fr_ra = FA'(rsel_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we_q) begin
			regs_q[rf_wa_q] <= rf_wd_q;
		end
		rf_rd_q <= rv_q[rf_ra] ? regs_q[rf_ra] : 8'h00;
		fr_rd_q <= fv_q[fr_ra] ? frame_q[fr_ra] : 64'h0;
		if (state_q == S_DWR) begin
			frame_q[FA'(drow_q)] <= fr_rd_q ^ draw_mask;
		end
		if (state_q == S_EXEC && op_q[15:12] == 4'h2) begin
			stack_q[sp_q] <= pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= c8i_pkg::CMD_LOAD;
			addr_q      <= '0;
			data_q      <= '0;
			key_q       <= '0;
			rnd_q       <= '0;
			rsel_q      <= '0;
			pc_q        <= c8i_pkg::PROGRAM_BASE;
			i_q         <= '0;
			sp_q        <= '0;
			delay_q     <= '0;
			sound_q     <= '0;
			seen_q      <= '0;
			op_hi_q     <= '0;
			op_q        <= '0;
			vx_q        <= '0;
			cnt_q       <= '0;
			x0_q        <= '0;
			y0_q        <= '0;
			drow_q      <= '0;
			hit_q       <= 1'b0;
			flag_q      <= 1'b0;
			bcd_q       <= '0;
			waiting_q   <= 1'b0;
			row_q       <= '0;
			rv_q        <= '0;
			rf_we_q     <= 1'b0;
			rf_wa_q     <= '0;
			rf_wd_q     <= '0;
			sv_q        <= '0;
			fv_q        <= '0;
			out_valid_q <= 1'b0;
			pc_out_q    <= '0;
			op_out_q    <= '0;
			delay_out_q <= '0;
			sound_out_q <= 1'b0;
			row_out_q   <= '0;
			wait_out_q  <= 1'b0;
		end else begin
			rf_we_q <= 1'b0;
			if (rf_we_q) begin
				rv_q[rf_wa_q] <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= command;
						addr_q    <= address;
						data_q    <= data;
						key_q     <= key_mask;
						rnd_q     <= random_byte;
						rsel_q    <= row_select;
						row_q     <= '0;
						waiting_q <= 1'b0;
						case (command)
							c8i_pkg::CMD_LOAD: state_q <= S_LOAD;
							c8i_pkg::CMD_EXEC: state_q <= S_FHI;
							c8i_pkg::CMD_READ: state_q <= S_RR;
							default:           state_q <= S_OUT;
						endcase
					end
				end
				S_LOAD: state_q <= S_OUT;
				S_RR:   state_q <= S_RR2;
				S_RR2: begin
					if (32'(rsel_q) < SCREEN_HEIGHT) begin
						row_q <= fr_rd_q;
					end
					state_q <= S_OUT;
				end
				S_FHI: state_q <= S_FLO;
				S_FLO: begin
					op_hi_q <= mem_rdata;
					state_q <= S_RX;
				end
				S_RX: begin
					op_q    <= {op_hi_q, mem_rdata};
					seen_q  <= {op_hi_q, mem_rdata};
					pc_q    <= pc_q + 12'd2;
					state_q <= S_RY;
				end
				S_RY: begin
					vx_q    <= rf_rd_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (op_q[15:12])
						4'h0: begin
							if (op_q == 16'h00E0) begin
								fv_q <= '0;
							end else if (op_q == 16'h00EE) begin
								sp_q <= sp_dec;
								pc_q <= sv_q[sp_dec] ? stack_q[sp_dec] : 12'h000;
							end
						end
						4'h1: pc_q <= nnn;
						4'h2: begin
							sv_q[sp_q] <= 1'b1;
							sp_q       <= sp_inc;
							pc_q       <= nnn;
						end
						4'h3: if (vx_q == kk) pc_q <= pc_skip;
						4'h4: if (vx_q != kk) pc_q <= pc_skip;
						4'h5: if (op_q[3:0] == 4'h0 && vx_q == rf_rd_q) pc_q <= pc_skip;
						4'h9: if (op_q[3:0] == 4'h0 && vx_q != rf_rd_q) pc_q <= pc_skip;
						4'h6: begin
							rf_we_q <= 1'b1;
							rf_wa_q <= ox;
							rf_wd_q <= kk;
						end
						4'h7: begin
							rf_we_q <= 1'b1;
							rf_wa_q <= ox;
							rf_wd_q <= vx_q + kk;
						end
						4'h8: begin
							rf_wa_q <= ox;
							case (op_q[3:0])
								4'h0: begin rf_we_q <= 1'b1; rf_wd_q <= rf_rd_q; end
								4'h1: begin rf_we_q <= 1'b1; rf_wd_q <= vx_q | rf_rd_q; end
								4'h2: begin rf_we_q <= 1'b1; rf_wd_q <= vx_q & rf_rd_q; end
								4'h3: begin rf_we_q <= 1'b1; rf_wd_q <= vx_q ^ rf_rd_q; end
								4'h4: begin
									rf_we_q <= 1'b1;
									rf_wd_q <= add9[7:0];
									flag_q  <= add9[8];
									state_q <= S_FLAG;
								end
								4'h5: begin
									rf_we_q <= 1'b1;
									rf_wd_q <= vx_q - rf_rd_q;
									flag_q  <= vx_q >= rf_rd_q;
									state_q <= S_FLAG;
								end
								4'h6: begin
									rf_we_q <= 1'b1;
									rf_wd_q <= {1'b0, vx_q[7:1]};
									flag_q  <= vx_q[0];
									state_q <= S_FLAG;
								end
								4'h7: begin
									rf_we_q <= 1'b1;
									rf_wd_q <= rf_rd_q - vx_q;
									flag_q  <= rf_rd_q >= vx_q;
									state_q <= S_FLAG;
								end
								4'hE: begin
									rf_we_q <= 1'b1;
									rf_wd_q <= {vx_q[6:0], 1'b0};
									flag_q  <= vx_q[7];
									state_q <= S_FLAG;
								end
								default: rf_we_q <= 1'b0;
							endcase
						end
						4'hA: i_q <= nnn;
						4'hB: pc_q <= nnn + 12'(rf_rd_q);
						4'hC: begin
							rf_we_q <= 1'b1;
							rf_wa_q <= ox;
							rf_wd_q <= rnd_q & kk;
						end
						4'hD: begin
							x0_q    <= 6'(c8i_pkg::mod_const(vx_q, 8'(SCREEN_WIDTH), RECIP_W));
							y0_q    <= 6'(c8i_pkg::mod_const(rf_rd_q, 8'(SCREEN_HEIGHT), RECIP_H));
							cnt_q   <= '0;
							hit_q   <= 1'b0;
							state_q <= S_DRD;
						end
						4'hE: begin
							if ((kk == 8'h9E && key_q[vx_q[3:0]]) ||
									(kk == 8'hA1 && !key_q[vx_q[3:0]])) begin
								pc_q <= pc_skip;
							end
						end
						default: begin
							case (kk)
								8'h07: begin
									rf_we_q <= 1'b1;
									rf_wa_q <= ox;
									rf_wd_q <= delay_q;
								end
								8'h0A: begin
									if (lk[4]) begin
										waiting_q <= 1'b1;
										pc_q      <= pc_q - 12'd2;
									end else begin
										rf_we_q <= 1'b1;
										rf_wa_q <= ox;
										rf_wd_q <= {4'h0, lk[3:0]};
									end
								end
								8'h15: delay_q <= vx_q;
								8'h18: sound_q <= vx_q;
								8'h1E: i_q <= i_q + 12'(vx_q);
								8'h29: i_q <= c8i_pkg::FONT_BASE + 12'(vx_q[3:0]) * 12'd5;
								8'h33: begin
									bcd_q   <= c8i_pkg::bcd(vx_q);
									cnt_q   <= '0;
									state_q <= S_BCD;
								end
								8'h55: begin
									cnt_q   <= '0;
									state_q <= S_STR;
								end
								8'h65: begin
									cnt_q   <= '0;
									state_q <= S_LDR;
								end
								default: state_q <= S_FIN;
							endcase
						end
					endcase
				end
				S_FLAG: begin
					rf_we_q <= 1'b1;
					rf_wa_q <= 4'hF;
					rf_wd_q <= {7'b0, flag_q};
					state_q <= S_FIN;
				end
				S_DRD: begin
					if (cnt_q == op_q[3:0] || 32'(drow) >= SCREEN_HEIGHT) begin
						flag_q  <= hit_q;
						state_q <= S_FLAG;
					end else begin
						drow_q  <= drow;
						state_q <= S_DWR;
					end
				end
				S_DWR: begin
					fv_q[FA'(drow_q)] <= 1'b1;
					if ((fr_rd_q & draw_mask) != 64'h0) begin
						hit_q <= 1'b1;
					end
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DRD;
				end
				S_BCD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd2) begin
						state_q <= S_FIN;
					end
				end
				S_STR: state_q <= S_STW;
				S_STW: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == ox) ? S_FIN : S_STR;
				end
				S_LDR: state_q <= S_LDW;
				S_LDW: begin
					rf_we_q <= 1'b1;
					rf_wa_q <= cnt_q;
					rf_wd_q <= mem_rdata;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == ox) ? S_FIN : S_LDR;
				end
				S_FIN: begin
					if (delay_q != 8'h00) begin
						delay_q <= delay_q - 1'b1;
					end
					if (sound_q != 8'h00) begin
						sound_q <= sound_q - 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pc_out_q    <= pc_q;
						op_out_q    <= seen_q;
						delay_out_q <= delay_q;
						sound_out_q <= sound_q != 8'h00;
						row_out_q   <= row_q;
						wait_out_q  <= waiting_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign program_counter = pc_out_q;
	assign last_opcode     = op_out_q;
	assign delay_count     = delay_out_q;
	assign sound_on        = sound_out_q;
	assign row_pixels      = row_out_q;
	assign waiting_key     = wait_out_q;

`ifndef SYNTHESIS
	a_fill_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!mem_ready |-> in_stall)
		else $error("input taken during memory fill");

	a_wait_only_fx0a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && waiting_key) |->
			(last_opcode[15:12] == 4'hF && last_opcode[7:0] == 8'h0A))
		else $error("waiting_key set for another opcode");

	a_call_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q[15:12] == 4'h2) |=>
			(sp_q == (($past(sp_q) == SP_LAST) ? '0 : $past(sp_q) + 1'b1)))
		else $error("stack pointer did not advance on call");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("result not loaded");
`endif
endmodule
`default_nettype wire
